FILE: rtl/dds_step_pulse_generator_defines.svh
// assertion macros used by the rtl
`ifndef DDS_STEP_PULSE_GENERATOR_DEFINES_SVH
`define DDS_STEP_PULSE_GENERATOR_DEFINES_SVH

// clocked check, disabled while reset is asserted
`define DSPG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define DSPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dspg_pkg.sv
package dspg_pkg;

    localparam int STEP_BIT_DEFAULT  = 22;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam int CMD_W   = 32;
    localparam int SCALE_W = 32;
    localparam int ACC_W   = 32;
    localparam int POS_W   = 32;

    localparam logic [SCALE_W-1:0] RATE_SCALE_RESET = SCALE_W'(27487790);

endpackage

FILE: rtl/dds_step_pulse_generator.sv
// an accepted input transaction is held in the stage 1 register, then in the stage 2 output register
// throughput: one transaction per cycle while out_stall is low; the multiply sits in the first stage and the
// accumulator add and step decision in the second, where the state lives
// reset: rst_n asynchronous active low; clears accumulator and position, direction forward,
// rate_scale back to its default, both pipeline stages empty
`include "dds_step_pulse_generator_defines.svh"

module dds_step_pulse_generator
    import dspg_pkg::*;
#(
    parameter int STEP_BIT  = STEP_BIT_DEFAULT,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     rate_scale_wr,
    input  logic [SCALE_W-1:0]       rate_scale_data,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [CMD_W-1:0]  freq_command,
    input  logic                     joint_enabled,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     step_pulse,
    output logic                     direction,
    output logic signed [POS_W-1:0]  position
);

    localparam int PROD_W = CMD_W + SCALE_W + 1;

    logic [SCALE_W-1:0]       rate_scale_reg;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic                     s1_en_reg;
    logic [ACC_W-1:0]         s1_inc_reg;
    logic [ACC_W-1:0]         s1_inc_next;

    logic                     out_valid_reg;
    logic                     pulse_reg;
    logic                     pulse_next;
    logic                     forward_reg;
    logic                     forward_next;
    logic [ACC_W-1:0]         accum_reg;
    logic [ACC_W-1:0]         accum_next;
    logic [POS_W-1:0]         count_reg;
    logic [POS_W-1:0]         count_next;

    logic                     advance;
    logic                     s1_load;
    logic signed [PROD_W-1:0] product;
    logic [ACC_W-1:0]         accum_sum;
    logic                     inc_forward;
    logic                     flipped;

    // output side moves when empty or taken
    assign advance  = !out_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || advance;
    assign in_stall = !s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_scale_reg <= RATE_SCALE_RESET;
        end
        else if (rate_scale_wr)
        begin
            rate_scale_reg <= rate_scale_data;
        end
    end

    // stage 1: signed command times unsigned scale, floor shift, keep 32 bits
    always_comb
    begin
        product       = $signed(freq_command) * $signed({1'b0, rate_scale_reg});
        s1_inc_next   = product[FRAC_BITS+ACC_W-1:FRAC_BITS];
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_inc_reg <= s1_inc_next;
            s1_en_reg  <= joint_enabled;
        end
    end

    // stage 2: accumulator, direction and step decision
    assign accum_sum   = accum_reg + s1_inc_reg;
    assign inc_forward = (s1_inc_reg != '0) && !s1_inc_reg[ACC_W-1];
    assign flipped     = accum_sum[STEP_BIT] ^ accum_reg[STEP_BIT];

    always_comb
    begin
        pulse_next   = pulse_reg;
        forward_next = forward_reg;
        accum_next   = accum_reg;
        count_next   = count_reg;
        if (advance && s1_valid_reg)
        begin
            pulse_next = 1'b0;
            if (s1_en_reg)
            begin
                accum_next = accum_sum;
                // a direction change eats the step of this tick
                if (inc_forward != forward_reg)
                begin
                    forward_next = inc_forward;
                end
                else if (flipped)
                begin
                    pulse_next = 1'b1;
                    count_next = inc_forward ? count_reg + POS_W'(1) : count_reg - POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pulse_reg     <= 1'b0;
            forward_reg   <= 1'b1;
            accum_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            pulse_reg   <= pulse_next;
            forward_reg <= forward_next;
            accum_reg   <= accum_next;
            count_reg   <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign step_pulse = pulse_reg;
    assign direction  = forward_reg;
    assign position   = $signed(count_reg);

    `DSPG_ASSERT(a_stall_only_when_full, in_stall |-> s1_valid_reg, "input stalled with empty stage")
    `DSPG_ASSERT_NEXT(a_disabled_holds, advance && s1_valid_reg && !s1_en_reg,
        !pulse_reg && $stable(count_reg) && $stable(accum_reg), "disabled tick changed state")
    `DSPG_ASSERT_NEXT(a_dir_change_no_step,
        advance && s1_valid_reg && s1_en_reg && (inc_forward != forward_reg),
        !pulse_reg && $stable(count_reg), "step taken on a direction change")
    `DSPG_ASSERT_NEXT(a_pulse_moves_count, advance && s1_valid_reg,
        pulse_reg == (count_reg != $past(count_reg)), "pulse and position out of step")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import dspg_pkg::*;

    localparam int STEP_POS  = STEP_BIT_DEFAULT;
    localparam int FRAC_POS  = FRAC_BITS_DEFAULT;
    localparam int CLK_HALF  = 6;

    typedef struct packed {
        logic                    step;
        logic                    fwd;
        logic signed [POS_W-1:0] pos;
    } tick_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      rate_scale_wr;
    logic [SCALE_W-1:0]        rate_scale_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [CMD_W-1:0]   freq_command;
    logic                      joint_enabled;
    logic                      out_valid;
    logic                      out_stall;
    logic                      step_pulse;
    logic                      direction;
    logic signed [POS_W-1:0]   position;

    // shadow copy of the step generator state
    logic [SCALE_W-1:0]        model_scale;
    logic [ACC_W-1:0]          model_accum;
    logic [POS_W-1:0]          model_count;
    logic                      model_forward;

    tick_result_t              expected_ticks[$];
    int                        error_count;
    bit                        in_gaps_on;
    bit                        out_gaps_on;
    int                        stall_left;

    dds_step_pulse_generator u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .rate_scale_wr   (rate_scale_wr),
        .rate_scale_data (rate_scale_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .freq_command    (freq_command),
        .joint_enabled   (joint_enabled),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .step_pulse      (step_pulse),
        .direction       (direction),
        .position        (position)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void predict_tick(input logic signed [CMD_W-1:0] cmd, input logic en);
        longint       prod;
        logic [31:0]  inc;
        logic [31:0]  old_acc;
        logic         fwd;
        logic         flip;
        tick_result_t r;
        r.step = 1'b0;
        if (en)
        begin
            prod    = longint'(cmd) * longint'({32'd0, model_scale});
            inc     = 32'(prod >>> FRAC_POS);
            old_acc = model_accum;
            model_accum = old_acc + inc;
            flip = old_acc[STEP_POS] ^ model_accum[STEP_POS];
            // zero increment reads as reverse
            fwd  = (inc != 32'd0) && !inc[31];
            if (fwd != model_forward)
                model_forward = fwd;
            else if (flip)
            begin
                r.step = 1'b1;
                model_count = fwd ? model_count + 1 : model_count - 1;
            end
        end
        r.fwd = model_forward;
        r.pos = model_count;
        expected_ticks.push_back(r);
    endfunction

    // must be called at a rising edge
    task automatic send_tick(input logic signed [CMD_W-1:0] cmd, input logic en);
        int gap;
        gap = in_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        freq_command  <= cmd;
        joint_enabled <= en;
        do
            @(posedge clk);
        while (in_stall);
        predict_tick(cmd, en);
    endtask

    task automatic wait_pipeline_empty();
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_rate_scale(input logic [SCALE_W-1:0] value);
        wait_pipeline_empty();
        rate_scale_wr   <= 1'b1;
        rate_scale_data <= value;
        @(posedge clk);
        rate_scale_wr   <= 1'b0;
        model_scale = value;
    endtask

    function automatic logic signed [CMD_W-1:0] pick_magnitude(input int kind);
        case (kind)
            0:       return $urandom_range(1, 40000);
            1:       return $urandom;
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    // receiving side: check each result transaction against the oldest expected tick
    initial
    begin
        tick_result_t want;
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_ticks.size() == 0)
                begin
                    $display("%0t: unexpected transaction step=%0b dir=%0b pos=%0d",
                             $time, step_pulse, direction, position);
                    error_count++;
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    if (step_pulse !== want.step)
                    begin
                        $display("%0t: step_pulse expected %0b actual %0b",
                                 $time, want.step, step_pulse);
                        error_count++;
                    end
                    if (direction !== want.fwd)
                    begin
                        $display("%0t: direction expected %0b actual %0b",
                                 $time, want.fwd, direction);
                        error_count++;
                    end
                    if (position !== want.pos)
                    begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.pos, position);
                        error_count++;
                    end
                end
                stall_left = out_gaps_on ? $urandom_range(0, 9) : 0;
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    task automatic test_directed_ticks();
        // near 2^22 per tick at the reset scale, so nearly every tick steps
        send_tick(32'sd10000, 1'b1);
        send_tick(32'sd10000, 1'b1);
        send_tick(32'sd10000, 1'b1);
        send_tick(32'sd10000, 1'b0);
        send_tick(-32'sd10000, 1'b1);
        send_tick(-32'sd10000, 1'b1);
        send_tick(-32'sd10000, 1'b1);
        send_tick(32'sd0, 1'b1);
        send_tick(32'sd0, 1'b1);
        send_tick(32'sd1, 1'b1);
        send_tick(32'sh7fffffff, 1'b1);
        send_tick(32'sh7fffffff, 1'b1);
        send_tick(32'sh80000000, 1'b1);
        send_tick(32'sh80000000, 1'b1);
        send_tick(-32'sd1, 1'b1);
        send_tick(32'sh80000000, 1'b0);
        send_tick(32'sd0, 1'b0);
        send_tick(32'sd20000, 1'b1);
        send_tick(32'sd20000, 1'b1);
        send_tick(32'sh7fffffff, 1'b0);
    endtask

    task automatic test_scale_extremes();
        logic [SCALE_W-1:0] scales[4];
        scales[0] = 32'd1;
        scales[1] = 32'hffffffff;
        scales[2] = 32'h00010000;
        scales[3] = 32'h80000000;
        foreach (scales[i])
        begin
            write_rate_scale(scales[i]);
            send_tick(32'sh7fffffff, 1'b1);
            send_tick(32'sh7fffffff, 1'b1);
            send_tick(32'sh80000000, 1'b1);
            send_tick(32'sh80000000, 1'b1);
            send_tick(-32'sd1, 1'b1);
            send_tick(32'sd1, 1'b1);
            send_tick(32'sd5000000, 1'b1);
            send_tick(32'sd5000000, 1'b1);
        end
    endtask

    task automatic test_random_runs();
        logic signed [CMD_W-1:0] mag;
        int                      run_len;
        int                      kind;
        bit                      neg;
        int                      sent;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       write_rate_scale(RATE_SCALE_RESET);
                1:       write_rate_scale(32'h00010000);
                2:       write_rate_scale($urandom);
                3:       write_rate_scale(RATE_SCALE_RESET);
                4:       write_rate_scale(32'hffffffff);
                default: write_rate_scale($urandom_range(32'h0010_0000, 32'h1000_0000));
            endcase
            // phase 0 runs back to back on both sides
            in_gaps_on  = (p != 0) && (p != 3);
            out_gaps_on = (p != 0) && (p != 4);
            sent = 0;
            while (sent < 250)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_tick($urandom, 1'($urandom_range(0, 1)));
                    sent++;
                end
                else
                begin
                    // run of commands sharing one sign flag, where steps accumulate
                    run_len = $urandom_range(1, 40);
                    kind    = $urandom_range(0, 2);
                    neg     = $urandom_range(0, 1);
                    for (int k = 0; k < run_len; k++)
                    begin
                        mag = pick_magnitude(kind);
                        send_tick(neg ? -mag : mag, ($urandom_range(0, 15) != 0));
                    end
                    sent += run_len;
                end
            end
        end
    endtask

    initial
    begin
        error_count     = 0;
        in_gaps_on      = 1'b0;
        out_gaps_on     = 1'b0;
        rst_n           = 1'b0;
        rate_scale_wr   = 1'b0;
        rate_scale_data = '0;
        in_valid        = 1'b0;
        freq_command    = '0;
        joint_enabled   = 1'b0;
        model_scale     = RATE_SCALE_RESET;
        model_accum     = '0;
        model_count     = '0;
        model_forward   = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ticks();
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
        test_scale_extremes();
        test_random_runs();

        wait_pipeline_empty();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
